[rtl/core/sptq_pkg.sv]
// Package: shared types, constants and codes for the sorted priority task queue
`timescale 1ns / 1ps
package sptq_pkg;
  localparam int unsigned Depth   = 16;
  localparam int unsigned IdxBits = $clog2(Depth);
  localparam int unsigned CntBits = $clog2(Depth + 1);

  // request codes
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_POP    = 3'd1;
  localparam logic [2:0] REQ_DELETE = 3'd2;
  localparam logic [2:0] REQ_JOB    = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] new_key;
    logic [15:0] new_payload;
    logic [3:0]  position;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] entry_key;
    logic [15:0] entry_payload;
    logic [3:0]  slot_used;
    logic [4:0]  entry_count;
  } rsp_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // capture request and evaluate
    logic commit;   // apply shift and update count, register result
  } cmd_t;
endpackage

[rtl/core/sorted_priority_task_queue_top.sv]
// Top level: sorted priority task queue
`timescale 1ns / 1ps
// Sorted priority task queue, 16 entries of key and payload in ascending key order.
// Request channel: in_valid / in_stall with payload req (insert, pop, delete at
// position, remove job-order entry, read position). Response channel:
// out_valid / out_stall with payload rsp (status, entry, slot, count).
// One transaction in gives exactly one transaction out.
// A request is captured at load, where all cells compare their keys with it;
// in the commit state the cell array shifts and the response is registered.
// No request is taken while one is in progress; a new request is taken in the
// same cycle the previous response is taken. The user writes job_order_key
// (cfg_we / cfg_data) only while the block is idle; it does not enforce this.
// Reset (rst, synchronous) empties the queue and clears job_order_key to 0;
// stored entries need no clearing since only occupied cells are read.
// While out_stall is high the response holds and no new request is taken.
module sorted_priority_task_queue_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sptq_pkg::req_t req,
  output logic           out_valid,
  input  logic           out_stall,
  output sptq_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data
);
  sptq_pkg::cmd_t cmd;
  logic [15:0] job_order_key;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) job_order_key <= '0;
    else if (cfg_we) job_order_key <= cfg_data;
  end

  sptq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
  );

  sptq_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(req),
    .job_order_key(job_order_key), .rsp(rsp)
  );
endmodule

[rtl/core/sptq_datapath.sv]
// Datapath: compare-and-shift cell array, request register and result register
`timescale 1ns / 1ps
module sptq_datapath (
  input  logic              clk,
  input  logic              rst,
  input  sptq_pkg::cmd_t    cmd,
  input  sptq_pkg::req_t    req,
  input  logic [15:0]       job_order_key,
  output sptq_pkg::rsp_t    rsp
);
  localparam int unsigned D = sptq_pkg::Depth;

  logic [15:0] keys [D];
  logic [15:0] pays [D];
  logic [sptq_pkg::CntBits-1:0] count;
  sptq_pkg::req_t r;

  // per-cell flags: gt and eqj are registered at load, the masks are combinational
  logic [D-1:0] gt, eqj, ins_mask, rem_mask;
  logic [D-1:0] occ_c, gt_c, eqj_c;
  logic [2:0] status_c;
  logic [sptq_pkg::IdxBits-1:0] slot_c;
  logic do_ins, do_rem;
  logic [15:0] okey_c, opay_c;
  logic [D-1:0] first_gt, first_eq;

  // per-cell compares on the live request
  always_comb begin
    for (int i = 0; i < D; i++) begin
      occ_c[i] = (sptq_pkg::CntBits'(i) < count);
      gt_c[i]  = occ_c[i] && (keys[i] > req.new_key);
      eqj_c[i] = occ_c[i] && (keys[i] == job_order_key);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r   <= req;
      gt  <= gt_c;
      eqj <= eqj_c;
    end
  end

  // first-match isolation on registered flags
  assign first_gt = gt & ~(gt - D'(1));
  assign first_eq = eqj & ~(eqj - D'(1));

  // decode of the request against registered state
  always_comb begin
    logic [sptq_pkg::IdxBits-1:0] ix;
    logic [sptq_pkg::CntBits-1:0] pc;
    ix = '0;
    pc = {{(sptq_pkg::CntBits-4){1'b0}}, r.position};
    status_c = sptq_pkg::ST_OK;
    slot_c = '0;
    do_ins = 1'b0;
    do_rem = 1'b0;
    okey_c = '0;
    opay_c = '0;
    ins_mask = '0;
    rem_mask = '0;
    case (r.req_type)
      sptq_pkg::REQ_INSERT: begin
        okey_c = r.new_key;
        opay_c = r.new_payload;
        if (count == sptq_pkg::CntBits'(D)) begin
          status_c = sptq_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
          ix = sptq_pkg::IdxBits'(count);
          for (int i = 0; i < D; i++) if (first_gt[i]) ix = sptq_pkg::IdxBits'(i);
          slot_c = ix;
        end
      end
      sptq_pkg::REQ_POP, sptq_pkg::REQ_DELETE, sptq_pkg::REQ_JOB,
      sptq_pkg::REQ_READ: begin
        if (count == '0) begin
          status_c = sptq_pkg::ST_EMPTY;
        end else if (r.req_type == sptq_pkg::REQ_JOB) begin
          if (eqj == '0) status_c = sptq_pkg::ST_NOTFOUND;
          else begin
            for (int i = 0; i < D; i++) if (first_eq[i]) ix = sptq_pkg::IdxBits'(i);
            do_rem = 1'b1;
          end
        end else if (r.req_type == sptq_pkg::REQ_POP) begin
          do_rem = 1'b1;
        end else if (pc >= count) begin
          status_c = sptq_pkg::ST_RANGE;
        end else begin
          ix = sptq_pkg::IdxBits'(r.position);
          do_rem = (r.req_type == sptq_pkg::REQ_DELETE);
        end
        if (status_c == sptq_pkg::ST_OK) begin
          slot_c = ix;
          okey_c = keys[ix];
          opay_c = pays[ix];
        end
      end
      default: ;
    endcase
    for (int i = 0; i < D; i++) begin
      ins_mask[i] = do_ins && (sptq_pkg::IdxBits'(i) >= slot_c);
      rem_mask[i] = do_rem && (sptq_pkg::IdxBits'(i) >= slot_c);
    end
  end

  // cell array: each cell loads the new entry, its left or right neighbor
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < D; i++) begin
        if (ins_mask[i]) begin
          if (sptq_pkg::IdxBits'(i) == slot_c) begin
            keys[i] <= r.new_key;
            pays[i] <= r.new_payload;
          end else begin
            keys[i] <= keys[(i + D - 1) % D];
            pays[i] <= pays[(i + D - 1) % D];
          end
        end else if (rem_mask[i] && i < D - 1) begin
          keys[i] <= keys[i + 1];
          pays[i] <= pays[i + 1];
        end
      end
    end
  end

  // occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      if (do_ins) count <= count + 1'b1;
      else if (do_rem) count <= count - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.status        <= status_c;
      rsp.entry_key     <= okey_c;
      rsp.entry_payload <= opay_c;
      rsp.slot_used     <= 4'(slot_c);
      rsp.entry_count   <= 5'(do_ins ? count + 1'b1 : (do_rem ? count - 1'b1 : count));
    end
  end
endmodule

[rtl/core/sptq_ctrl.sv]
// Controller: sequences load, commit and result delivery
`timescale 1ns / 1ps
module sptq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output sptq_pkg::cmd_t cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state, state_next;

  // accept when idle, or as the held result leaves
  assign in_stall  = !((state == S_IDLE) || (state == S_OUT && !out_stall));
  assign out_valid = (state == S_OUT);
  assign cmd.load   = in_valid && !in_stall;
  assign cmd.commit = (state == S_EVAL);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EVAL;
      S_EVAL: state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) state_next = in_valid ? S_EVAL : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end
endmodule
